FILE: rtl/core/osme_pkg.sv
// Shared types and codes for the origin-shift maze engine.
`timescale 1ns / 1ps

package osme_pkg;

    typedef logic [3:0] t_link;

    localparam t_link LINK_NONE = 4'b0000;
    localparam t_link LINK_N    = 4'b0001;
    localparam t_link LINK_S    = 4'b0010;
    localparam t_link LINK_W    = 4'b0100;
    localparam t_link LINK_E    = 4'b1000;

    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_RSVD    = 2'd3;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_E = 2'd3;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_EDGE   = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [6:0] SIZE_RESET = 7'd16;

endpackage

FILE: rtl/core/osme_grid_ram.sv
// Single-port grid memory of cell links with registered read data.
`timescale 1ns / 1ps

module osme_grid_ram #(
    parameter int ADDR_W = 12
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_addr,
    input  osme_pkg::t_link     i_wdata,
    output osme_pkg::t_link     o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    osme_pkg::t_link r_mem [DEPTH];
    osme_pkg::t_link r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/origin_shift_maze_engine.sv
// Top level of the origin-shift maze engine: request sequencer around the grid memory.
`timescale 1ns / 1ps

// Origin-shift maze engine. The grid of one-hot cell links (N, S, W, E, zero at the
// origin) lives in one single-port memory of 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT))
// entries, addressed {row, col}. Each request on the slave stream gives exactly one
// result transfer on the master stream. A step writes the old origin, then clears the
// new origin, one memory write each, and writes nothing when rejected at the edge; a
// read of the expanded map makes two memory reads on the one port when it touches
// links; a restart runs a fill pass over the whole memory (4096 entries at 64 x 64),
// one entry a cycle. After reset the same fill pass runs once with a 16 x 16 grid and
// no input is taken until it ends. The size registers only take effect at the next
// restart. The origin_dir field is always zero since the origin cell is cleared by
// every restart and every step.

module origin_shift_maze_engine #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // dir_choice[1:0], map_x[9:2], map_y[17:10], zero fill
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // blocked[0], origin_x[6:1], origin_y[12:7],
                                        // origin_dir[16:13], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import osme_pkg::*;

    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW  = CW + RW;
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_RD_A,
        ST_RD_B,
        ST_DONE
    } t_state;

    // size register to active size: zero counts as one, large values saturate
    function automatic int f_clamp(input logic [6:0] v, input int mx);
        if (v == 7'd0) begin
            return 1;
        end
        if (int'(v) > mx) begin
            return mx;
        end
        return int'(v);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [6:0] col, input logic [6:0] row);
        return {RW'(row), CW'(col)};
    endfunction

    t_state           r_state;
    logic [6:0]       r_cfg_w;
    logic [6:0]       r_cfg_h;
    logic [SWW-1:0]   r_act_w;
    logic [SWH-1:0]   r_act_h;
    logic [CW-1:0]    r_origin_col;
    logic [RW-1:0]    r_origin_row;
    logic [AW-1:0]    r_clr_addr;
    logic             r_restart_pend;
    logic [AW-1:0]    r_addr_b;
    logic             r_need_a;
    logic             r_need_b;
    t_link            r_mask_a;
    t_link            r_mask_b;
    logic             r_hit;
    logic [1:0]       r_status;
    logic             r_blocked;
    logic             r_m_valid;
    logic [23:0]      r_m_tdata;
    logic [1:0]       r_m_tuser;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    t_link            mem_wdata;
    t_link            mem_rdata;

    // request fields
    logic             in_xfer;
    logic [1:0]       req_type;
    logic [1:0]       req_dir;
    logic [7:0]       req_mx;
    logic [7:0]       req_my;
    logic [6:0]       half_x;
    logic [6:0]       half_y;

    // step decode
    t_link            step_link;
    logic             step_edge;
    logic [CW-1:0]    n_origin_col;
    logic [RW-1:0]    n_origin_row;

    // read decode
    logic             rd_oob;
    logic             rd_need_a;
    logic             rd_need_b;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;
    t_link            rd_mask_a;
    t_link            rd_mask_b;

    // fill pattern
    logic [CW-1:0]    clr_col;
    logic [RW-1:0]    clr_row;
    t_link            clr_link;
    logic             clr_last;

    logic             out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign req_type = s_axis_tuser;
    assign req_dir  = s_axis_tdata[1:0];
    assign req_mx   = s_axis_tdata[9:2];
    assign req_my   = s_axis_tdata[17:10];
    assign half_x   = req_mx[7:1];
    assign half_y   = req_my[7:1];

    assign out_free = !r_m_valid || m_axis_tready;

    // fill pattern: east everywhere, south down the last column, zero at the corner
    // and outside the active size
    assign clr_col  = r_clr_addr[CW-1:0];
    assign clr_row  = r_clr_addr[AW-1:CW];
    assign clr_last = (r_clr_addr == {AW{1'b1}});

    always_comb begin
        clr_link = LINK_NONE;
        if (int'(clr_col) < int'(r_act_w) && int'(clr_row) < int'(r_act_h)) begin
            if (int'(clr_col) + 1 < int'(r_act_w)) begin
                clr_link = LINK_E;
            end else if (int'(clr_row) + 1 < int'(r_act_h)) begin
                clr_link = LINK_S;
            end
        end
    end

    // step: edge check and new origin
    always_comb begin
        step_link    = t_link'(4'b0001 << req_dir);
        n_origin_col = r_origin_col;
        n_origin_row = r_origin_row;
        unique case (req_dir)
            DIR_N: begin
                step_edge    = (r_origin_row == '0);
                n_origin_row = r_origin_row - RW'(1);
            end
            DIR_S: begin
                step_edge    = (int'(r_origin_row) + 1 >= int'(r_act_h));
                n_origin_row = r_origin_row + RW'(1);
            end
            DIR_W: begin
                step_edge    = (r_origin_col == '0);
                n_origin_col = r_origin_col - CW'(1);
            end
            DIR_E: begin
                step_edge    = (int'(r_origin_col) + 1 >= int'(r_act_w));
                n_origin_col = r_origin_col + CW'(1);
            end
            default: begin
                step_edge = 1'b1;
            end
        endcase
    end

    // read: a wall square between two cells is open when either side links across
    always_comb begin
        rd_oob    = (int'(req_mx) >= 2 * int'(r_act_w) + 1) ||
                    (int'(req_my) >= 2 * int'(r_act_h) + 1);
        rd_need_a = 1'b0;
        rd_need_b = 1'b0;
        rd_addr_a = f_addr(half_x, half_y);
        rd_addr_b = f_addr(half_x, half_y);
        rd_mask_a = LINK_NONE;
        rd_mask_b = LINK_NONE;
        if (req_mx[0] && !req_my[0]) begin
            // horizontal wall: cell above links south, cell below links north
            rd_need_a = (half_y != 7'd0);
            rd_need_b = (int'(half_y) < int'(r_act_h));
            rd_addr_a = f_addr(half_x, half_y - 7'd1);
            rd_mask_a = LINK_S;
            rd_mask_b = LINK_N;
        end else if (!req_mx[0] && req_my[0]) begin
            // vertical wall: left cell links east, right cell links west
            rd_need_a = (half_x != 7'd0);
            rd_need_b = (int'(half_x) < int'(r_act_w));
            rd_addr_a = f_addr(half_x - 7'd1, half_y);
            rd_mask_a = LINK_E;
            rd_mask_b = LINK_W;
        end
    end

    // memory port mux
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr_b;
        mem_wdata = LINK_NONE;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = clr_link;
            end
            ST_IDLE: begin
                if (req_type == REQ_STEP) begin
                    mem_we    = in_xfer && !step_edge;
                    mem_addr  = {r_origin_row, r_origin_col};
                    mem_wdata = step_link;
                end else begin
                    mem_addr  = rd_addr_a;
                end
            end
            ST_STEP: begin
                // origin registers already hold the new origin
                mem_we    = 1'b1;
                mem_addr  = {r_origin_row, r_origin_col};
                mem_wdata = LINK_NONE;
            end
            ST_RD_A: begin
                mem_addr  = r_addr_b;
            end
            ST_RD_B, ST_DONE: begin
                mem_addr  = r_addr_b;
            end
            default: begin
                mem_addr  = r_addr_b;
            end
        endcase
    end

    osme_grid_ram #(
        .ADDR_W (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= SIZE_RESET;
            r_cfg_h <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg_h <= i_cfg_wdata;
                default:    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_act_w        <= SWW'(f_clamp(SIZE_RESET, MAX_WIDTH));
            r_act_h        <= SWH'(f_clamp(SIZE_RESET, MAX_HEIGHT));
            r_origin_col   <= CW'(f_clamp(SIZE_RESET, MAX_WIDTH) - 1);
            r_origin_row   <= RW'(f_clamp(SIZE_RESET, MAX_HEIGHT) - 1);
            r_clr_addr     <= '0;
            r_restart_pend <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            // ST_DONE loads the next result itself when the register frees up
            if (m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (clr_last) begin
                        r_state        <= r_restart_pend ? ST_DONE : ST_IDLE;
                        r_restart_pend <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        unique case (req_type)
                            REQ_RESTART: begin
                                r_status       <= STAT_DONE;
                                r_blocked      <= 1'b0;
                                r_act_w        <= SWW'(f_clamp(r_cfg_w, MAX_WIDTH));
                                r_act_h        <= SWH'(f_clamp(r_cfg_h, MAX_HEIGHT));
                                r_origin_col   <= CW'(f_clamp(r_cfg_w, MAX_WIDTH) - 1);
                                r_origin_row   <= RW'(f_clamp(r_cfg_h, MAX_HEIGHT) - 1);
                                r_clr_addr     <= '0;
                                r_restart_pend <= 1'b1;
                                r_state        <= ST_CLEAR;
                            end
                            REQ_STEP: begin
                                r_blocked <= 1'b0;
                                if (step_edge) begin
                                    r_status <= STAT_EDGE;
                                    r_state  <= ST_DONE;
                                end else begin
                                    r_status     <= STAT_DONE;
                                    r_origin_col <= n_origin_col;
                                    r_origin_row <= n_origin_row;
                                    r_state      <= ST_STEP;
                                end
                            end
                            REQ_READ: begin
                                if (rd_oob) begin
                                    r_status  <= STAT_RANGE;
                                    r_blocked <= 1'b1;
                                    r_state   <= ST_DONE;
                                end else if (req_mx[0] == req_my[0]) begin
                                    // odd/odd is a cell, even/even a corner post
                                    r_status  <= STAT_DONE;
                                    r_blocked <= !req_mx[0];
                                    r_state   <= ST_DONE;
                                end else begin
                                    r_status <= STAT_DONE;
                                    r_need_a <= rd_need_a;
                                    r_need_b <= rd_need_b;
                                    r_mask_a <= rd_mask_a;
                                    r_mask_b <= rd_mask_b;
                                    r_addr_b <= rd_addr_b;
                                    r_state  <= ST_RD_A;
                                end
                            end
                            REQ_RSVD: begin
                                r_status  <= STAT_DONE;
                                r_blocked <= 1'b0;
                                r_state   <= ST_DONE;
                            end
                            default: begin
                                r_status  <= STAT_DONE;
                                r_blocked <= 1'b0;
                                r_state   <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_STEP: begin
                    r_state <= ST_DONE;
                end
                ST_RD_A: begin
                    // first neighbor's link is on the read port now
                    r_hit   <= r_need_a && ((mem_rdata & r_mask_a) != LINK_NONE);
                    r_state <= ST_RD_B;
                end
                ST_RD_B: begin
                    r_blocked <= !(r_hit ||
                                   (r_need_b && ((mem_rdata & r_mask_b) != LINK_NONE)));
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_tuser <= r_status;
                        r_m_tdata <= {7'd0, LINK_NONE, 6'(r_origin_row),
                                      6'(r_origin_col), r_blocked};
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

FILE: verif/tb_origin_shift_maze_engine.sv
// Self-checking testbench for the origin-shift maze engine request and result streams.
`timescale 1ns / 1ps

module tb_origin_shift_maze_engine;
    import osme_pkg::*;

    localparam int GRID_MAX      = 64;  // matches the default MAX_WIDTH / MAX_HEIGHT
    localparam int SETTLE_CYCLES = 4;   // idle margin before a size register write
    localparam int TAIL_CYCLES   = 16;  // quiet time after the last result

    // One result transfer, split into its fields.
    typedef struct packed {
        logic [1:0] status;
        logic       blocked;
        logic [5:0] ox;
        logic [5:0] oy;
        t_link      odir;
    } maze_result_t;

    // One row of the directed table: either a size register write or a request.
    typedef struct {
        bit           is_cfg;
        logic         cfg_sel;
        logic [6:0]   cfg_val;
        logic [1:0]   req;
        logic [1:0]   dir;
        logic [7:0]   mx;
        logic [7:0]   my;
        bit           typed;    // expected result written in the row itself
        maze_result_t want;
    } plan_row_t;

    // DUT inputs start at known values, before any clock edge.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_WIDTH;
    logic [6:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // dir_choice[1:0], map_x[9:2], map_y[17:10]
    logic [1:0]  s_axis_tuser  = REQ_RSVD;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // blocked[0], origin_x[6:1], origin_y[12:7],
                                       // origin_dir[16:13]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    origin_shift_maze_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin : clock_gen
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (reset fill, a few dozen restart fills,
    // every transfer stalled on both sides) is well under a tenth of this.
    initial begin : run_limit
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Maze model: grid of links [row][col], size registers, latched size,
    // origin position.
    // ------------------------------------------------------------------
    t_link       grid_links [GRID_MAX][GRID_MAX];
    int unsigned reg_w, reg_h;      // size registers as last written
    int unsigned live_w, live_h;    // size latched at the last restart
    int unsigned org_c, org_r;

    maze_result_t pending_results[$];   // expected results, oldest first

    int unsigned mismatches, results_checked, cfg_writes;
    int unsigned cnt_restart, cnt_step, cnt_edge, cnt_read, cnt_range, cnt_rsvd;

    bit quiet;  // when set, neither side inserts gaps

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // Restart pattern: east everywhere, south down the last column,
    // origin in the bottom-right corner, nothing outside the active area.
    function automatic void rebuild_grid();
        live_w = clamp_dim(reg_w);
        live_h = clamp_dim(reg_h);
        for (int unsigned r = 0; r < GRID_MAX; r++) begin
            for (int unsigned c = 0; c < GRID_MAX; c++) begin
                grid_links[r][c] = LINK_NONE;
                if (r < live_h && c < live_w) begin
                    if (c + 1 < live_w) grid_links[r][c] = LINK_E;
                    else if (r + 1 < live_h) grid_links[r][c] = LINK_S;
                end
            end
        end
        org_c = live_w - 1;
        org_r = live_h - 1;
    endfunction

    function automatic t_link link_of(int unsigned c, int unsigned r);
        if (c >= live_w || r >= live_h) return LINK_NONE;
        return grid_links[r][c];
    endfunction

    // Expanded map square: odd/odd is a cell (open), even/even a post (wall),
    // the rest are walls opened by a link from either neighbor.
    function automatic logic wall_at(int unsigned mx, int unsigned my);
        int unsigned col, row, far;
        if ((mx & 1) != 0 && (my & 1) != 0) return 1'b0;
        if ((mx & 1) == 0 && (my & 1) == 0) return 1'b1;
        if ((mx & 1) != 0) begin
            // horizontal wall between row far-1 and row far
            col = (mx - 1) >> 1;
            far = my >> 1;
            if (far > 0 && (link_of(col, far - 1) & LINK_S) != 0) return 1'b0;
            if ((link_of(col, far) & LINK_N) != 0) return 1'b0;
            return 1'b1;
        end
        // vertical wall between column far-1 and column far
        row = (my - 1) >> 1;
        far = mx >> 1;
        if (far > 0 && (link_of(far - 1, row) & LINK_E) != 0) return 1'b0;
        if ((link_of(far, row) & LINK_W) != 0) return 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted request to the model and returns its result.
    function automatic maze_result_t apply_request(logic [1:0] req, logic [1:0] dir,
                                                   logic [7:0] mx, logic [7:0] my);
        maze_result_t res;
        t_link        step_link;
        bit           off_grid;
        res = '0;
        case (req)
            REQ_RESTART: rebuild_grid();
            REQ_STEP: begin
                case (dir)
                    DIR_N: begin
                        step_link = LINK_N;
                        off_grid  = (org_r == 0);
                    end
                    DIR_S: begin
                        step_link = LINK_S;
                        off_grid  = (org_r + 1 >= live_h);
                    end
                    DIR_W: begin
                        step_link = LINK_W;
                        off_grid  = (org_c == 0);
                    end
                    default: begin
                        step_link = LINK_E;
                        off_grid  = (org_c + 1 >= live_w);
                    end
                endcase
                if (off_grid) begin
                    res.status = STAT_EDGE;
                end else begin
                    // old origin points at the new one, new origin is cleared
                    grid_links[org_r][org_c] = step_link;
                    case (dir)
                        DIR_N:   org_r--;
                        DIR_S:   org_r++;
                        DIR_W:   org_c--;
                        default: org_c++;
                    endcase
                    grid_links[org_r][org_c] = LINK_NONE;
                end
            end
            REQ_READ: begin
                if (mx >= 2 * live_w + 1 || my >= 2 * live_h + 1) begin
                    res.status  = STAT_RANGE;
                    res.blocked = 1'b1;
                end else begin
                    res.blocked = wall_at(mx, my);
                end
            end
            default: ;  // reserved request: no change
        endcase
        res.ox   = org_c[5:0];
        res.oy   = org_r[5:0];
        res.odir = link_of(org_c, org_r);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Gaps: mostly none, some short, a few long.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side backpressure, changed at the falling edge.
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                hold = pick_gap();
                m_axis_tready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        maze_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, m_axis_tuser);
                compare_field("blocked", want.blocked, m_axis_tdata[0]);
                compare_field("origin_x", want.ox, m_axis_tdata[6:1]);
                compare_field("origin_y", want.oy, m_axis_tdata[12:7]);
                compare_field("origin_dir", want.odir, m_axis_tdata[16:13]);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drives one request after a random gap, waits for its transfer, then
    // records the expected result. tvalid stays high into the next request
    // when that one has no gap.
    task automatic issue_request(logic [1:0] req, logic [1:0] dir,
                                 logic [7:0] mx, logic [7:0] my,
                                 bit typed = 1'b0, maze_result_t want = '0);
        maze_result_t predicted;
        int unsigned  gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {6'd0, my, mx, dir};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_request(req, dir, mx, my);
        pending_results.push_back(typed ? want : predicted);
        case (req)
            REQ_RESTART: cnt_restart++;
            REQ_STEP: begin
                cnt_step++;
                if (predicted.status == STAT_EDGE) cnt_edge++;
            end
            REQ_READ: begin
                cnt_read++;
                if (predicted.status == STAT_RANGE) cnt_range++;
            end
            default: cnt_rsvd++;
        endcase
    endtask

    // Holds off new requests until every pending result has been taken.
    task automatic wait_results_done();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Size registers are only written with the engine idle.
    task automatic write_size(logic sel, logic [6:0] val);
        wait_results_done();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_WIDTH) reg_w = val;
        else reg_h = val;
        cfg_writes++;
    endtask

    // Random request: steps and reads dominate; reads mostly land inside the
    // active map, many around the origin where the links change.
    task automatic random_item();
        int unsigned roll;
        logic [1:0]  req, dir;
        logic [7:0]  mx, my;
        roll = $urandom_range(0, 99);
        dir  = 2'($urandom);
        mx   = 8'($urandom);
        my   = 8'($urandom);
        if (roll < 3) req = REQ_RESTART;
        else if (roll < 6) req = REQ_RSVD;
        else if (roll < 50) req = REQ_STEP;
        else begin
            req  = REQ_READ;
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                mx = 8'(2 * org_c + $urandom_range(0, 4) - 1);
                my = 8'(2 * org_r + $urandom_range(0, 4) - 1);
            end else if (roll < 9) begin
                mx = 8'($urandom_range(0, 2 * live_w));
                my = 8'($urandom_range(0, 2 * live_h));
            end
        end
        issue_request(req, dir, mx, my);
    endtask

    // Table row builders.
    function automatic plan_row_t req_row(logic [1:0] req, logic [1:0] dir,
                                          logic [7:0] mx, logic [7:0] my);
        plan_row_t row;
        row        = '{default: '0};
        row.req    = req;
        row.dir    = dir;
        row.mx     = mx;
        row.my     = my;
        return row;
    endfunction

    function automatic plan_row_t typed_row(logic [1:0] req, logic [1:0] dir,
                                            logic [7:0] mx, logic [7:0] my,
                                            logic [1:0] status, logic blocked,
                                            logic [5:0] ox, logic [5:0] oy);
        plan_row_t row;
        row       = req_row(req, dir, mx, my);
        row.typed = 1'b1;
        row.want  = '{status, blocked, ox, oy, LINK_NONE};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic sel, logic [6:0] val);
        plan_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        plan_row_t   plan[$];
        int unsigned phase_w[6];
        int unsigned phase_h[6];

        reg_w = SIZE_RESET;
        reg_h = SIZE_RESET;
        rebuild_grid();
        quiet = 1'b0;

        // Directed part. Reset grid is 16 x 16 with the origin at (15, 15).
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd0, 8'd0, STAT_DONE, 1'b1, 6'd15, 6'd15));
        plan.push_back(typed_row(REQ_RSVD, DIR_E, 8'd255, 8'd255,
                                 STAT_DONE, 1'b0, 6'd15, 6'd15));
        plan.push_back(typed_row(REQ_STEP, DIR_E, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd15, 6'd15));
        plan.push_back(typed_row(REQ_STEP, DIR_S, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd15, 6'd15));
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd255, 8'd255,
                                 STAT_RANGE, 1'b1, 6'd15, 6'd15));
        // first column past the map edge
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd33, 8'd5, STAT_RANGE, 1'b1, 6'd15, 6'd15));
        // corner post on the far edge
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd32, 8'd32, STAT_DONE, 1'b1, 6'd15, 6'd15));
        // cell square is always open
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd31, 8'd31, STAT_DONE, 1'b0, 6'd15, 6'd15));
        plan.push_back(req_row(REQ_STEP, DIR_N, 8'd0, 8'd0));
        plan.push_back(req_row(REQ_STEP, DIR_W, 8'd0, 8'd0));
        plan.push_back(req_row(REQ_READ, DIR_N, 8'd30, 8'd29));
        plan.push_back(typed_row(REQ_RESTART, DIR_N, 8'd0, 8'd0,
                                 STAT_DONE, 1'b0, 6'd15, 6'd15));
        // zero sizes clamp to a single cell, but only at the next restart
        plan.push_back(cfg_row(CFG_WIDTH, 7'd0));
        plan.push_back(cfg_row(CFG_HEIGHT, 7'd0));
        plan.push_back(req_row(REQ_READ, DIR_N, 8'd1, 8'd1));
        plan.push_back(typed_row(REQ_RESTART, DIR_N, 8'd0, 8'd0, STAT_DONE, 1'b0, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_STEP, DIR_N, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_STEP, DIR_S, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_STEP, DIR_W, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_STEP, DIR_E, 8'd0, 8'd0, STAT_EDGE, 1'b0, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd3, 8'd1, STAT_RANGE, 1'b1, 6'd0, 6'd0));
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd2, 8'd2, STAT_DONE, 1'b1, 6'd0, 6'd0));
        // oversize registers saturate to 64 x 64
        plan.push_back(cfg_row(CFG_WIDTH, 7'd127));
        plan.push_back(cfg_row(CFG_HEIGHT, 7'd127));
        plan.push_back(typed_row(REQ_RESTART, DIR_N, 8'd0, 8'd0,
                                 STAT_DONE, 1'b0, 6'd63, 6'd63));
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd128, 8'd128,
                                 STAT_DONE, 1'b1, 6'd63, 6'd63));
        plan.push_back(typed_row(REQ_READ, DIR_N, 8'd129, 8'd0,
                                 STAT_RANGE, 1'b1, 6'd63, 6'd63));
        plan.push_back(req_row(REQ_STEP, DIR_W, 8'd0, 8'd0));
        plan.push_back(req_row(REQ_STEP, DIR_N, 8'd0, 8'd0));

        // Synchronous reset is held first; the engine then runs its fill pass
        // and holds tready low until it is done.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_size(plan[i].cfg_sel, plan[i].cfg_val);
            else issue_request(plan[i].req, plan[i].dir, plan[i].mx, plan[i].my,
                               plan[i].typed, plan[i].want);
        end

        // Random part: six size settings, narrow and flat strips among them.
        phase_w = '{2, 1, 64, 5, $urandom_range(1, 12), $urandom_range(0, 127)};
        phase_h = '{3, 64, 1, 4, $urandom_range(1, 12), $urandom_range(0, 127)};
        for (int ph = 0; ph < 6; ph++) begin
            write_size(CFG_WIDTH, 7'(phase_w[ph]));
            write_size(CFG_HEIGHT, 7'(phase_h[ph]));
            // a few requests still on the previous size
            repeat (3) random_item();
            issue_request(REQ_RESTART, 2'($urandom), 8'($urandom), 8'($urandom));
            for (int j = 0; j < 85; j++) begin
                if (j % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
                // full stop mid-phase: let the result side catch up completely
                if (ph == 3 && j == 40) wait_results_done();
                random_item();
            end
        end
        quiet = 1'b0;

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d restarts, %0d steps (%0d refused at the edge), %0d map reads",
                 cnt_restart, cnt_step, cnt_edge, cnt_read);
        $display("(%0d out of range), %0d reserved, %0d size writes; %0d results checked",
                 cnt_range, cnt_rsvd, cfg_writes, results_checked);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/osme_pkg.sv
rtl/core/osme_grid_ram.sv
rtl/core/origin_shift_maze_engine.sv
verif/tb_origin_shift_maze_engine.sv
